[sv/ptrm_pkg.sv]
package ptrm_pkg;

    localparam int HISTORY_LEN_DEF = 32;

    localparam int PROB_W  = 8;
    localparam int COUNT_W = 6;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [PROB_W-1:0] CUTOFF_RESET = 8'd128;

    // register index, taken from paddr[2]
    localparam logic REG_CUTOFF = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic take;
    } t_fold_ctl;

endpackage

[sv/ptrm_ram.sv]
module ptrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ptrm_fold.sv]
module ptrm_fold #(
    parameter int CW = 6
) (
    input  logic                       i_clk,
    input  ptrm_pkg::t_fold_ctl        i_ctl,
    input  logic [ptrm_pkg::PROB_W-1:0] i_data,
    input  logic [ptrm_pkg::PROB_W-1:0] i_cutoff,
    output logic [CW-1:0]              o_active,
    output logic [ptrm_pkg::PROB_W-1:0] o_peak,
    output logic [ptrm_pkg::PROB_W-1:0] o_rise
);

    import ptrm_pkg::*;

    logic [CW-1:0]     r_active, n_active;
    logic [PROB_W-1:0] r_peak, n_peak;
    logic [PROB_W-1:0] r_run_min, n_run_min;
    logic [PROB_W-1:0] r_trough, n_trough;
    logic [PROB_W-1:0] w_min;

    // trough is the running minimum captured each time a strictly higher peak shows up
    always_comb begin
        w_min     = (i_data < r_run_min) ? i_data : r_run_min;
        n_active  = r_active;
        n_peak    = r_peak;
        n_run_min = r_run_min;
        n_trough  = r_trough;
        if (i_ctl.clear) begin
            n_active  = '0;
            n_peak    = '0;
            n_run_min = '1;
            n_trough  = '0;
        end else if (i_ctl.take) begin
            n_run_min = w_min;
            if (i_data >= i_cutoff) begin
                n_active = r_active + CW'(1);
            end
            if (i_data > r_peak) begin
                n_peak   = i_data;
                n_trough = w_min;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_active  <= n_active;
        r_peak    <= n_peak;
        r_run_min <= n_run_min;
        r_trough  <= n_trough;
    end

    assign o_active = r_active;
    assign o_peak   = r_peak;
    assign o_rise   = r_peak - r_trough;

endmodule

[sv/probability_trace_rise_metrics.sv]
// channel   | dir | tdata (low bit up)                               | tuser
// ----------+-----+--------------------------------------------------+-------
// i_s_*     | in  | probability[7:0]                                 | -
// o_m_*     | out | fill_count, active_count, peak_value, climb_sc.  | stored
// APB       | in  | active_cutoff at byte address 0                  | -
//
// An item goes through these steps: accept, one history read per held entry
// through the single RAM read port, the fold of each read as its data returns,
// the close of the walk, and the load of the output.
// Reset (synchronous, active low) empties the history and sets active_cutoff to 128.
// Input is taken only while idle; a finished result waits in the output register
// and the next item can be accepted meanwhile. Its own result then waits for the slot.
module probability_trace_rise_metrics #(
    parameter int HISTORY_LEN = ptrm_pkg::HISTORY_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,   // [7:0] probability

    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [31:0]                  o_m_tdata,   // [5:0] fill_count, [11:6] active_count,
                                                      // [19:12] peak_value, [27:20] climb_score
    output logic                         o_m_tuser,   // [0] stored

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptrm_pkg::APB_AW-1:0]  paddr,
    input  logic [ptrm_pkg::APB_DW-1:0]  pwdata,
    output logic [ptrm_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    import ptrm_pkg::*;

    localparam int AW = $clog2(HISTORY_LEN);
    localparam int CW = $clog2(HISTORY_LEN + 1);

    t_state r_state, n_state;

    logic [PROB_W-1:0] r_cutoff;
    logic [AW-1:0]     r_wp, n_wp;
    logic [CW-1:0]     r_count, n_count;
    logic [PROB_W-1:0] r_last;
    logic              r_keep;
    logic [AW-1:0]     r_rd_addr;
    logic [CW-1:0]     r_issued;
    logic              r_dv;

    logic              r_out_valid;
    logic              r_out_stored;
    logic [COUNT_W-1:0] r_out_fill;
    logic [COUNT_W-1:0] r_out_active;
    logic [PROB_W-1:0] r_out_peak;
    logic [PROB_W-1:0] r_out_rise;

    logic              w_accept;
    logic              w_keep;
    logic              w_issue;
    logic              w_scan_done;
    logic              w_load_out;
    logic              w_cfg_wr;
    t_fold_ctl         w_fold;
    logic [PROB_W-1:0] w_rdata;
    logic [CW-1:0]     w_active;
    logic [PROB_W-1:0] w_peak;
    logic [PROB_W-1:0] w_rise;

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CUTOFF);
    assign prdata   = (paddr[2] == REG_CUTOFF) ? {{(APB_DW-PROB_W){1'b0}}, r_cutoff} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RESET;
        end else if (w_cfg_wr) begin
            r_cutoff <= pwdata[PROB_W-1:0];
        end
    end

    // history update
    assign w_accept = i_s_tvalid && o_s_tready;
    // a zero after a stored zero is dropped
    assign w_keep   = (i_s_tdata != '0) || (r_count == '0) || (r_last != '0);

    always_comb begin
        n_wp    = r_wp;
        n_count = r_count;
        if (w_keep) begin
            n_wp = (r_wp == AW'(HISTORY_LEN - 1)) ? '0 : r_wp + AW'(1);
            if (r_count != CW'(HISTORY_LEN)) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_count <= '0;
        end else if (w_accept) begin
            r_wp    <= n_wp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_keep <= w_keep;
            if (w_keep) begin
                r_last <= i_s_tdata;
            end
        end
    end

    assign w_scan_done = !w_issue && !r_dv;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_fold     = '0;
        w_issue    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                w_fold.clear = i_s_tvalid;
            end
            ST_SCAN: begin
                w_issue     = (r_issued != r_count);
                w_fold.take = r_dv;
            end
            ST_FINISH: begin
                w_load_out = !r_out_valid || i_m_tready;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= w_issue;
        end
    end

    // read walk, oldest entry first; before the ring wraps the oldest sits at slot 0
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_addr <= (n_count == CW'(HISTORY_LEN)) ? n_wp : '0;
            r_issued  <= '0;
        end else if (w_issue) begin
            r_rd_addr <= (r_rd_addr == AW'(HISTORY_LEN - 1)) ? '0 : r_rd_addr + AW'(1);
            r_issued  <= r_issued + CW'(1);
        end
    end

    ptrm_ram #(
        .WIDTH (PROB_W),
        .DEPTH (HISTORY_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_keep),
        .i_waddr (r_wp),
        .i_wdata (i_s_tdata),
        .i_re    (w_issue),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    ptrm_fold #(
        .CW (CW)
    ) u_fold (
        .i_clk    (i_clk),
        .i_ctl    (w_fold),
        .i_data   (w_rdata),
        .i_cutoff (r_cutoff),
        .o_active (w_active),
        .o_peak   (w_peak),
        .o_rise   (w_rise)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_stored <= r_keep;
            r_out_fill   <= COUNT_W'(r_count);
            r_out_active <= COUNT_W'(w_active);
            r_out_peak   <= w_peak;
            r_out_rise   <= w_rise;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_stored;
    assign o_m_tdata  = {4'b0, r_out_rise, r_out_peak, r_out_active, r_out_fill};

    property p_fill_tracks_wp;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_count != CW'(HISTORY_LEN)) |-> (r_wp == AW'(r_count));
    endproperty
    a_fill_tracks_wp: assert property (p_fill_tracks_wp)
        else $error("write pointer out of step with fill count before wrap");

    property p_issue_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issued <= r_count);
    endproperty
    a_issue_bound: assert property (p_issue_bound)
        else $error("history walk read past the held entries");

    property p_take_in_scan;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == ST_SCAN);
    endproperty
    a_take_in_scan: assert property (p_take_in_scan)
        else $error("read data returned outside the scan");

    property p_scan_end;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && w_scan_done) |=> (r_state == ST_FINISH);
    endproperty
    a_scan_end: assert property (p_scan_end)
        else $error("scan did not finish after the last read");

    property p_count_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> (r_count != '0);
    endproperty
    a_count_nonzero: assert property (p_count_nonzero)
        else $error("result formed over an empty history");

endmodule

[tb/sv/probability_trace_rise_metrics_test.sv]
`timescale 1ns / 1ps

module probability_trace_rise_metrics_test;
    import ptrm_pkg::*;

    localparam int HIST_DEPTH    = HISTORY_LEN_DEF;
    localparam int ITEMS_PHASE   = 225;
    localparam int NUM_PHASES    = 8;
    localparam int SETTLE_CYCLES = HIST_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 1_500_000;

    localparam logic [APB_AW-1:0] ADDR_CUTOFF = 3'd0;
    // decodes to register index 1, which does not exist
    localparam logic [APB_AW-1:0] ADDR_SPARE  = 3'd4;

    typedef struct packed {
        logic       stored;
        logic [5:0] fill;
        logic [5:0] active;
        logic [7:0] peak;
        logic [7:0] rise;
    } t_trace_result;

    typedef struct packed {
        logic [7:0]    prob;
        logic          typed;
        t_trace_result res;
    } t_stim_row;

    localparam int NUM_ROWS = 18;

    // typed rows assume the reset cutoff of 128
    t_stim_row directed_rows [NUM_ROWS] = '{
        '{8'd0,   1'b1, '{1'b1, 6'd1, 6'd0, 8'd0,   8'd0}},
        '{8'd0,   1'b1, '{1'b0, 6'd1, 6'd0, 8'd0,   8'd0}},
        '{8'd255, 1'b1, '{1'b1, 6'd2, 6'd1, 8'd255, 8'd255}},
        '{8'd128, 1'b1, '{1'b1, 6'd3, 6'd2, 8'd255, 8'd255}},
        '{8'd127, 1'b1, '{1'b1, 6'd4, 6'd2, 8'd255, 8'd255}},
        '{8'd0,   1'b1, '{1'b1, 6'd5, 6'd2, 8'd255, 8'd255}},
        '{8'd0,   1'b1, '{1'b0, 6'd5, 6'd2, 8'd255, 8'd255}},
        '{8'd1,   1'b0, '0},
        '{8'd2,   1'b0, '0},
        '{8'd4,   1'b0, '0},
        '{8'd8,   1'b0, '0},
        '{8'd16,  1'b0, '0},
        '{8'd32,  1'b0, '0},
        '{8'd64,  1'b0, '0},
        '{8'd255, 1'b0, '0},
        '{8'd3,   1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd254, 1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [7:0]         i_s_tdata;   // [7:0] probability
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [31:0]        o_m_tdata;   // [5:0] fill, [11:6] active, [19:12] peak, [27:20] rise
    logic               o_m_tuser;   // [0] stored
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    probability_trace_rise_metrics u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // history shadow
    logic [7:0]    hist_shadow [HIST_DEPTH];
    logic [4:0]    shadow_wr_pos;
    int unsigned   shadow_count;
    logic [7:0]    shadow_cutoff;

    t_trace_result pending_metrics [$];
    int            errors;
    int            cycles;
    int            stall_left;
    bit            no_idle;
    int            ramp_level;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_metrics.size());
            $display("probability_trace_rise_metrics verification failed");
            $finish;
        end
    end

    task automatic compute_rise_metrics(input logic [7:0] prob, output t_trace_result res);
        logic        keep;
        logic [4:0]  oldest;
        logic [4:0]  slot;
        logic [7:0]  val;
        logic [7:0]  peak;
        logic [7:0]  trough;
        int unsigned active;
        int unsigned peak_idx;
        keep = 1'b1;
        active = 0;
        peak = 8'd0;
        peak_idx = 0;
        if (prob == 8'd0 && shadow_count > 0 && hist_shadow[shadow_wr_pos - 5'd1] == 8'd0)
            keep = 1'b0;
        if (keep) begin
            hist_shadow[shadow_wr_pos] = prob;
            shadow_wr_pos = shadow_wr_pos + 5'd1;
            if (shadow_count < HIST_DEPTH)
                shadow_count++;
        end
        oldest = shadow_wr_pos - 5'(shadow_count);
        for (int i = 0; i < shadow_count; i++) begin
            slot = oldest + 5'(i);
            val = hist_shadow[slot];
            if (val >= shadow_cutoff)
                active++;
            if (val > peak) begin
                peak = val;
                peak_idx = i;
            end
        end
        trough = peak;
        for (int i = 0; i < shadow_count && i <= peak_idx; i++) begin
            slot = oldest + 5'(i);
            if (hist_shadow[slot] < trough)
                trough = hist_shadow[slot];
        end
        res.stored = keep;
        res.fill   = 6'(shadow_count);
        res.active = 6'(active);
        res.peak   = peak;
        res.rise   = peak - trough;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_trace_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_metrics.size() == 0) begin
                $display("%0t: result transaction with nothing expected, tdata %h tuser %b",
                         $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = pending_metrics.pop_front();
                check_field("stored", want.stored, o_m_tuser);
                check_field("fill_count", want.fill, o_m_tdata[5:0]);
                check_field("active_count", want.active, o_m_tdata[11:6]);
                check_field("peak_value", want.peak, o_m_tdata[19:12]);
                check_field("climb_score", want.rise, o_m_tdata[27:20]);
            end
        end
    end

    // output back-pressure: mostly ready, short and occasional long stalls
    always @(negedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_m_tready = 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_m_tready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < 70) begin
            i_m_tready = 1'b1;
        end else begin
            i_m_tready = 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 3);
        end
    end

    function automatic int sender_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function logic [7:0] next_probability(input int mode);
        int lvl;
        case (mode)
            0: begin
                lvl = $urandom_range(0, 9);
                if (lvl < 3)
                    return 8'd0;
                if (lvl == 3)
                    return 8'd255;
                return 8'($urandom_range(0, 255));
            end
            1: begin
                // narrow range: many ties for the peak
                if ($urandom_range(0, 9) < 3)
                    return 8'd0;
                return 8'($urandom_range(1, 7));
            end
            2: begin
                if ($urandom_range(0, 9) == 0)
                    ramp_level = 0;
                else
                    ramp_level = ramp_level + int'($urandom_range(0, 40)) - 15;
                if (ramp_level < 0)
                    ramp_level = 0;
                if (ramp_level > 255)
                    ramp_level = 255;
                return 8'(ramp_level);
            end
            default: begin
                if ($urandom_range(0, 4) == 0)
                    return 8'd0;
                lvl = int'(shadow_cutoff) + int'($urandom_range(0, 4)) - 2;
                if (lvl < 0)
                    lvl = 0;
                if (lvl > 255)
                    lvl = 255;
                return 8'(lvl);
            end
        endcase
    endfunction

    task automatic send_probability(input logic [7:0] prob, input int gap, input logic typed,
                                    input t_trace_result typed_res);
        t_trace_result res;
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = prob;
        do @(posedge i_clk); while (!o_s_tready);
        compute_rise_metrics(prob, res);
        pending_metrics.insert(pending_metrics.size(), typed ? typed_res : res);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_metrics.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rd);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        if (wr && addr[2] == REG_CUTOFF)
            shadow_cutoff = data[7:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_cutoff_readback();
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, ADDR_CUTOFF, '0, rd);
        if (rd !== {24'd0, shadow_cutoff}) begin
            $display("%0t: active_cutoff readback mismatch, expected %0d, got %0d",
                     $time, shadow_cutoff, rd);
            errors++;
        end
    endtask

    initial begin : stimulus
        logic [APB_DW-1:0] rd;
        logic [APB_DW-1:0] wdata;
        logic [7:0]        cutoff;
        errors     = 0;
        no_idle    = 1'b0;
        ramp_level = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
            hist_shadow[i] = 8'd0;
        shadow_wr_pos = '0;
        shadow_count  = 0;
        shadow_cutoff = CUTOFF_RESET;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        check_cutoff_readback();

        foreach (directed_rows[i])
            send_probability(directed_rows[i].prob, sender_gap(), directed_rows[i].typed,
                             directed_rows[i].res);
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       cutoff = 8'd0;
                1:       cutoff = 8'd255;
                2:       cutoff = 8'd1;
                3:       cutoff = 8'd254;
                default: cutoff = 8'($urandom_range(0, 255));
            endcase
            // unused upper bits carry noise
            wdata = $urandom();
            wdata[7:0] = cutoff;
            apb_access(1'b1, ADDR_CUTOFF, wdata, rd);
            if (ph == 4)
                apb_access(1'b1, ADDR_SPARE, $urandom(), rd);
            check_cutoff_readback();

            no_idle = (ph == 3);
            for (int n = 0; n < ITEMS_PHASE; n++)
                send_probability(next_probability(ph % 4), sender_gap(), 1'b0, '0);
            // sender holds off here until every result of the phase is back
            drain_results();
        end

        if (pending_metrics.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_metrics.size());
            errors++;
        end
        if (errors == 0)
            $display("probability_trace_rise_metrics verification clean");
        else
            $display("probability_trace_rise_metrics verification failed");
        $finish;
    end

endmodule
